FILE: hdl/cfpr_pkg.sv
package cfpr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hA1;
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd200;
  localparam logic [CRC_W-1:0]  CRC_INIT        = 16'hFFFF;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] max_payload_length;
  } cfg_t;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic              packet_done;
    logic              crc_ok;
    logic [BYTE_W-1:0] packet_type;
    logic [BYTE_W-1:0] packet_length;
  } result_t;

  // CRC-16/MCRF4XX, one byte per call (reflected 0x8408)
  function automatic logic [CRC_W-1:0] crc16_step(input logic [BYTE_W-1:0] b,
                                                   input logic [CRC_W-1:0]  crc);
    logic [BYTE_W-1:0] x;
    x = b ^ crc[7:0];
    x = x ^ {x[3:0], 4'b0000};
    return {x, crc[15:8]} ^ {12'b0, x[7:4]} ^ {5'b0, x, 3'b000};
  endfunction

endpackage

FILE: hdl/cfpr_front.sv
module cfpr_front
  import cfpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              push_ready,
  output logic              push_valid,
  output result_t           push_data
);

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_TYPE    = 6'b000010,
    PH_LENGTH  = 6'b000100,
    PH_CRC_LO  = 6'b001000,
    PH_CRC_HI  = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] length_r, length_nxt;
  logic [CRC_W-1:0]  rcv_crc_r, rcv_crc_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;

  logic              accept;
  logic [CRC_W-1:0]  crc_upd;
  logic [CRC_W-1:0]  rcv_full;
  logic [BYTE_W-1:0] count_inc;

  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;
  assign crc_upd   = crc16_step(rx_byte, crc_r);
  assign rcv_full  = {rx_byte, rcv_crc_r[7:0]};
  assign count_inc = count_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    length_nxt  = length_r;
    rcv_crc_nxt = rcv_crc_r;
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    push_valid  = 1'b0;
    push_data   = '0;
    push_data.packet_type   = type_r;
    push_data.packet_length = length_r;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == cfg.start_byte) begin
            phase_nxt = PH_TYPE;
            count_nxt = '0;
            crc_nxt   = CRC_INIT;
          end
        end
        PH_TYPE: begin
          type_nxt  = rx_byte;
          crc_nxt   = crc16_step(rx_byte, CRC_INIT);
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (rx_byte > cfg.max_payload_length) begin
            // oversized: drop silently
            phase_nxt = PH_HUNT;
            count_nxt = '0;
            crc_nxt   = CRC_INIT;
          end else begin
            length_nxt = rx_byte;
            crc_nxt    = crc_upd;
            phase_nxt  = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          rcv_crc_nxt = {8'h00, rx_byte};
          phase_nxt   = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          rcv_crc_nxt = rcv_full;
          count_nxt   = '0;
          if (length_r == '0) begin
            push_valid            = 1'b1;
            push_data.packet_done = 1'b1;
            push_data.crc_ok      = (rcv_full == crc_r);
            phase_nxt             = PH_HUNT;
            crc_nxt               = CRC_INIT;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          push_valid              = 1'b1;
          push_data.payload_valid = 1'b1;
          push_data.payload_byte  = rx_byte;
          push_data.payload_index = count_r;
          crc_nxt                 = crc_upd;
          count_nxt               = count_inc;
          if (count_inc >= length_r) begin
            push_data.packet_done = 1'b1;
            push_data.crc_ok      = (rcv_crc_r == crc_upd);
            phase_nxt             = PH_HUNT;
            count_nxt             = '0;
            crc_nxt               = CRC_INIT;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          crc_nxt   = CRC_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      type_r    <= '0;
      length_r  <= '0;
      rcv_crc_r <= '0;
      crc_r     <= CRC_INIT;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      type_r    <= type_nxt;
      length_r  <= length_nxt;
      rcv_crc_r <= rcv_crc_nxt;
      crc_r     <= crc_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

FILE: hdl/cfpr_queue.sv
module cfpr_queue
  import cfpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  result_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  result_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    priority if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hdl/cfpr_back.sv
module cfpr_back
  import cfpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  result_t pop_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    valid_r;
  result_t data_r;

  // Load whenever the output register is empty or being drained
  assign pop_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      data_r <= pop_data;
    end
  end

endmodule

FILE: hdl/crc16_framed_packet_receiver.sv
// Path: the front writes each result into the queue at the accepting edge, and the
//   output register loads it from the queue when it is empty or being drained.
// Throughput: one byte per cycle; a two-entry queue plus the output register absorb
//   output stalls, and in_ready drops only when the queue is full.
// Reset (rst_n low, synchronous): receiver hunts for the start byte, registers return
//   to start byte 0xA1 and length limit 200, queue and output are emptied.
module crc16_framed_packet_receiver
  import cfpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_payload_valid,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [BYTE_W-1:0]    out_payload_index,
  output logic                 out_packet_done,
  output logic                 out_crc_ok,
  output logic [BYTE_W-1:0]    out_packet_type,
  output logic [BYTE_W-1:0]    out_packet_length
);

  cfg_t    cfg_r;
  logic    push_valid, push_ready;
  result_t push_data;
  logic    pop_valid, pop_ready;
  result_t pop_data;
  result_t out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte         <= START_BYTE_RST;
      cfg_r.max_payload_length <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE:  cfg_r.start_byte         <= cfg_wdata;
        CFG_MAX_PAYLOAD: cfg_r.max_payload_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cfpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (in_rx_byte),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  cfpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cfpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_payload_valid = out_data.payload_valid;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_index = out_data.payload_index;
  assign out_packet_done   = out_data.packet_done;
  assign out_crc_ok        = out_data.crc_ok;
  assign out_packet_type   = out_data.packet_type;
  assign out_packet_length = out_data.packet_length;

endmodule

FILE: hdl/cfpr_checker.sv
module cfpr_checker
  import cfpr_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_payload_valid,
  input logic [BYTE_W-1:0]    out_payload_byte,
  input logic [BYTE_W-1:0]    out_payload_index,
  input logic                 out_packet_done,
  input logic                 out_crc_ok,
  input logic [BYTE_W-1:0]    out_packet_length
);

  // Output register empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_payload_index) && $stable(out_packet_done) && $stable(out_crc_ok))
    else $error("stalled result changed");

  // A result without payload must close a packet
  a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_packet_done
      && out_payload_byte == 8'd0 && out_payload_index == 8'd0)
    else $error("result with neither payload nor packet end");

  // Verdict only on packet end
  a_ok_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crc_ok |-> out_packet_done)
    else $error("crc verdict outside packet end");

  // Payload index never reaches the packet length
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_payload_index < out_packet_length)
    else $error("payload index beyond length");

endmodule

bind crc16_framed_packet_receiver cfpr_checker u_cfpr_checker (.*);

FILE: dv/tb.sv
module tb;
  import cfpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 300;

  typedef enum logic [2:0] {
    RX_HUNT, RX_TYPE, RX_LENGTH, RX_CRC_LO, RX_CRC_HI, RX_PAYLOAD
  } rx_phase_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    bit                wait_idle;
  } rx_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START_BYTE;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_payload_valid;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic [BYTE_W-1:0]    out_payload_index;
  logic                 out_packet_done;
  logic                 out_crc_ok;
  logic [BYTE_W-1:0]    out_packet_type;
  logic [BYTE_W-1:0]    out_packet_length;

  crc16_framed_packet_receiver uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_valid(out_payload_valid),
    .out_payload_byte (out_payload_byte),
    .out_payload_index(out_payload_index),
    .out_packet_done  (out_packet_done),
    .out_crc_ok       (out_crc_ok),
    .out_packet_type  (out_packet_type),
    .out_packet_length(out_packet_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver tracking state
  logic [BYTE_W-1:0] cur_start  = START_BYTE_RST;
  logic [BYTE_W-1:0] cur_max    = MAX_PAYLOAD_RST;
  rx_phase_t         rx_phase   = RX_HUNT;
  logic [BYTE_W-1:0] rx_type    = '0;
  logic [BYTE_W-1:0] rx_len     = '0;
  logic [CRC_W-1:0]  rx_crc     = '0;
  logic [CRC_W-1:0]  crc_acc    = CRC_INIT;
  logic [BYTE_W-1:0] rx_count   = '0;

  rx_req_t rx_bytes_q[$];
  result_t frame_results[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_payload = 0;
  int n_frames = 0;
  int n_crc_bad = 0;
  int err_cnt = 0;
  int n_settings = 0;
  int cycle_cnt = 0;
  int hold_req = 0;
  bit in_gaps_on = 1'b1;
  bit out_stall_on = 1'b1;

  // Bitwise reflected CRC, one byte
  function automatic logic [CRC_W-1:0] crc_mcrf(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ 16'h8408) : (v >> 1);
    end
    return v;
  endfunction

  function automatic void rx_restart();
    rx_phase = RX_HUNT;
    rx_count = '0;
    crc_acc  = CRC_INIT;
  endfunction

  // Advance the receiver by one byte; queue the frame result it produces
  function automatic void track_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    bit      emit;
    bit      done;
    r = '0;
    emit = 1'b0;
    done = 1'b0;
    case (rx_phase)
      RX_HUNT: begin
        if (b == cur_start) begin
          rx_restart();
          rx_phase = RX_TYPE;
        end
      end
      RX_TYPE: begin
        rx_type  = b;
        crc_acc  = crc_mcrf(CRC_INIT, b);
        rx_phase = RX_LENGTH;
      end
      RX_LENGTH: begin
        if (b > cur_max) begin
          rx_restart();
        end else begin
          rx_len   = b;
          crc_acc  = crc_mcrf(crc_acc, b);
          rx_phase = RX_CRC_LO;
        end
      end
      RX_CRC_LO: begin
        rx_crc   = {8'h00, b};
        rx_phase = RX_CRC_HI;
      end
      RX_CRC_HI: begin
        rx_crc[15:8] = b;
        rx_count = '0;
        if (rx_len == 0) begin
          emit = 1'b1;
          done = 1'b1;
        end else begin
          rx_phase = RX_PAYLOAD;
        end
      end
      RX_PAYLOAD: begin
        emit = 1'b1;
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = rx_count;
        crc_acc  = crc_mcrf(crc_acc, b);
        rx_count = rx_count + 8'd1;
        if (rx_count >= rx_len) done = 1'b1;
      end
      default: rx_restart();
    endcase
    if (emit) begin
      r.packet_done   = done;
      r.crc_ok        = done && (rx_crc == crc_acc);
      r.packet_type   = rx_type;
      r.packet_length = rx_len;
      frame_results.push_back(r);
    end
    if (done) rx_restart();
  endfunction

  // Driver: one request per handshake, random gap after each when gaps are on
  int in_gap = 0;
  always @(posedge clk) begin : drv
    logic              nv;
    logic [BYTE_W-1:0] nd;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= '0;
    end else begin
      nv = in_valid;
      nd = in_rx_byte;
      if (in_valid && in_ready) begin
        track_byte(in_rx_byte);
        n_accepted++;
        nv = 1'b0;
        in_gap = in_gaps_on ? $urandom_range(0, 19) : 0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (rx_bytes_q.size() > 0 &&
                     !(rx_bytes_q[0].wait_idle && frame_results.size() > 0)) begin
          nd = rx_bytes_q[0].data;
          nv = 1'b1;
          void'(rx_bytes_q.pop_front());
        end
      end
      in_valid <= nv;
      in_rx_byte <= nd;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: result %0d %s mismatch: expected %0h actual %0h",
               $time, n_results, name, want, got);
    end
  endtask

  // Long output hold, counted on its own
  int hold_left = 0;
  int hold_taken = 0;
  always @(posedge clk) begin : hold_ctl
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_req) begin
      hold_taken <= hold_req;
      hold_left <= LONG_HOLD;
    end
  end

  // Monitor: check each result, stall at random, drop ready during long holds
  int out_stall = 0;
  always @(posedge clk) begin : mon
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none actual byte %0h done %0b",
                   $time, out_payload_byte, out_packet_done);
        end else begin
          want = frame_results.pop_front();
          check_field("payload_valid", 8'(want.payload_valid), 8'(out_payload_valid));
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("payload_index", want.payload_index, out_payload_index);
          check_field("packet_done", 8'(want.packet_done), 8'(out_packet_done));
          check_field("crc_ok", 8'(want.crc_ok), 8'(out_crc_ok));
          check_field("packet_type", want.packet_type, out_packet_type);
          check_field("packet_length", want.packet_length, out_packet_length);
          if (want.payload_valid) n_payload++;
          if (want.packet_done) n_frames++;
          if (want.packet_done && !want.crc_ok) n_crc_bad++;
        end
        n_results++;
        out_stall = out_stall_on ? $urandom_range(0, 19) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (hold_left == 0) && (out_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, frame_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input bit wait_idle);
    rx_req_t req;
    req.data = b;
    req.wait_idle = wait_idle;
    rx_bytes_q.push_back(req);
    n_queued++;
  endtask

  task automatic add_frame(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] typ,
                           input logic [BYTE_W-1:0] len, input bit bad_crc,
                           input bit wait_idle);
    logic [BYTE_W-1:0] body[$];
    logic [CRC_W-1:0]  crc;
    crc = crc_mcrf(crc_mcrf(CRC_INIT, typ), len);
    for (int i = 0; i < len; i++) begin
      body.push_back(BYTE_W'($urandom_range(0, 255)));
      crc = crc_mcrf(crc, body[i]);
    end
    if (bad_crc) crc ^= CRC_W'($urandom_range(1, 16'hFFFF));
    push_byte(sb, wait_idle);
    push_byte(typ, 1'b0);
    push_byte(len, 1'b0);
    push_byte(crc[7:0], 1'b0);
    push_byte(crc[15:8], 1'b0);
    foreach (body[i]) push_byte(body[i], 1'b0);
  endtask

  task automatic wait_quiet();
    while (n_accepted != n_queued || frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] maxlen);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_wdata <= sb;
    cur_start = sb;
    @(posedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_wdata <= maxlen;
    cur_max = maxlen;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Mostly well-formed frames; some bad CRC, oversized, truncated and noise
  task automatic gen_traffic(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] maxlen,
                             input int budget);
    int                base;
    int                pick;
    int                n;
    bit                paused;
    bit                hold;
    logic [BYTE_W-1:0] cap;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] b;
    base = n_queued;
    paused = 1'b0;
    cap = (maxlen < 12) ? maxlen : 8'd12;
    while (n_queued - base < budget) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? maxlen : BYTE_W'($urandom_range(0, cap));
      // hold one frame back mid-phase until every result is in
      hold = !paused && (n_queued - base) >= budget / 2;
      if (hold) paused = 1'b1;
      if (pick >= 80 && pick < 88 && maxlen != 8'hFF) begin
        push_byte(sb, hold);
        push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        push_byte(BYTE_W'($urandom_range(maxlen + 1, 255)), 1'b0);
      end else if (pick >= 88 && pick < 94) begin
        push_byte(sb, hold);
        push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        push_byte(BYTE_W'($urandom_range(0, cap)), 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
      end else if (pick >= 94) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          b = BYTE_W'($urandom_range(0, 255));
          if (b == sb) b = ~b;
          push_byte(b, hold && i == 0);
        end
      end else begin
        add_frame(sb, BYTE_W'($urandom_range(0, 255)), len, pick >= 70, hold);
      end
    end
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] maxlen,
                           input bit gaps, input bit stalls, input bit long_hold,
                           input int budget);
    write_regs(sb, maxlen);
    in_gaps_on = gaps;
    out_stall_on = stalls;
    if (long_hold) hold_req++;
    if (maxlen == 8'hFF) begin
      add_frame(sb, BYTE_W'($urandom_range(0, 255)), maxlen, 1'b0, 1'b0);
    end
    gen_traffic(sb, maxlen, budget);
    wait_quiet();
  endtask

  initial begin : stim
    logic [BYTE_W-1:0] rs;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme bytes as noise, empty payloads with good and bad CRC,
    // oversized length, short payload ending in a combined byte/done result
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    add_frame(START_BYTE_RST, 8'hFF, 8'd0, 1'b0, 1'b0);
    add_frame(START_BYTE_RST, 8'h00, 8'd0, 1'b1, 1'b0);
    push_byte(START_BYTE_RST, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(MAX_PAYLOAD_RST + 8'd1, 1'b0);
    add_frame(START_BYTE_RST, 8'h33, 8'd2, 1'b0, 1'b0);
    wait_quiet();

    run_phase(8'h00, 8'd0, 1'b0, 1'b0, 1'b0, 180);
    run_phase(8'hFF, 8'd255, 1'b0, 1'b0, 1'b1, 120);
    run_phase(START_BYTE_RST, 8'd8, 1'b1, 1'b0, 1'b0, 180);
    rs = BYTE_W'($urandom_range(0, 255));
    run_phase(rs, BYTE_W'($urandom_range(1, 30)), 1'b0, 1'b1, 1'b0, 180);
    rs = BYTE_W'($urandom_range(0, 255));
    run_phase(rs, 8'd12, 1'b1, 1'b1, 1'b0, 180);
    run_phase(8'h7E, 8'd1, 1'b1, 1'b1, 1'b0, 130);

    $display("Run: %0d bytes in, %0d results, %0d payload bytes, %0d frames (%0d bad CRC)",
             n_accepted, n_results, n_payload, n_frames, n_crc_bad);
    $display("Run: %0d register settings incl. extremes, long output hold, drain pauses",
             n_settings);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
